FILE: sv/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg : shared types and constants of the sorted key set engine
// opcodes, status codes, controller states and the command / flag bundles
// that pass between the controller and the datapath
// ----------------------------------------------------------------------------
package sks_pkg;

  // default sizing of the table
  localparam int CAPACITY_DEF    = 256;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed port widths
  localparam int OPCODE_W   = 3;
  localparam int PORT_KEY_W = 32;
  localparam int PORT_VAL_W = 32;
  localparam int INDEX_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int POS_W      = 8;
  localparam int COUNT_W    = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FIND   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_MISS  = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_RANGE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HINT,
    S_SCAN,
    S_RESOLVE,
    S_SHUP,
    S_INS,
    S_RMRD,
    S_SHDN,
    S_RDRD
  } state_t;

  // source of the position, key and value of a result
  typedef enum logic [2:0] {
    OSEL_NONE,
    OSEL_FOUND,
    OSEL_NEW,
    OSEL_HOLD_IDX,
    OSEL_RDATA_IDX
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     scan_hint;
    logic     scan_zero;
    logic     scan_adv;
    logic     rd_idx;
    logic     rm_capture;
    logic     shdn_step;
    logic     shup_begin;
    logic     shup_step;
    logic     ins_write;
    logic     commit_ins;
    logic     commit_rm;
    logic     commit_clr;
    logic     out_load;
    status_t  status;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    used_zero;
    logic    hint_lt_used;
    logic    key_ge_rdata;
    logic    p_inc_ge_used;
    logic    found;
    logic    full;
    logic    used_gt_p;
    logic    j_eq_p;
    logic    idx_in_ok;
    logic    idx_inc_lt_used;
    logic    j_inc_lt_used;
  } dp_flags_t;

endpackage

FILE: sv/sks_ram.sv
// ----------------------------------------------------------------------------
// sks_ram : generic simple dual port ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module sks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/sks_ctrl.sv
// ----------------------------------------------------------------------------
// sks_ctrl : operation sequencer
// walks the table for search and shift, issues datapath commands
// ----------------------------------------------------------------------------
module sks_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [sks_pkg::OPCODE_W-1:0]        in_opcode,
  input  sks_pkg::dp_flags_t                  flags,
  output sks_pkg::dp_cmd_t                    cmd,
  output logic                                busy
);

  sks_pkg::state_t state_r;
  sks_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != sks_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sks_pkg::S_IDLE: begin
        if (start) begin
          case (sks_pkg::opcode_t'(in_opcode))
            sks_pkg::OP_FIND, sks_pkg::OP_INSERT: begin
              if (flags.used_zero) begin
                state_nxt = sks_pkg::S_RESOLVE;
              end else if (flags.hint_lt_used) begin
                state_nxt = sks_pkg::S_HINT;
              end else begin
                state_nxt = sks_pkg::S_SCAN;
              end
            end
            sks_pkg::OP_REMOVE: begin
              if (flags.idx_in_ok) begin
                state_nxt = sks_pkg::S_RMRD;
              end
            end
            sks_pkg::OP_READ: begin
              if (flags.idx_in_ok) begin
                state_nxt = sks_pkg::S_RDRD;
              end
            end
            default: state_nxt = sks_pkg::S_IDLE;
          endcase
        end
      end
      sks_pkg::S_HINT: begin
        if (flags.key_ge_rdata && flags.p_inc_ge_used) begin
          state_nxt = sks_pkg::S_RESOLVE;
        end else begin
          state_nxt = sks_pkg::S_SCAN;
        end
      end
      sks_pkg::S_SCAN: begin
        if (!flags.key_ge_rdata || flags.p_inc_ge_used) begin
          state_nxt = sks_pkg::S_RESOLVE;
        end
      end
      sks_pkg::S_RESOLVE: begin
        if (flags.found || flags.op == sks_pkg::OP_FIND || flags.full) begin
          state_nxt = sks_pkg::S_IDLE;
        end else if (flags.used_gt_p) begin
          state_nxt = sks_pkg::S_SHUP;
        end else begin
          state_nxt = sks_pkg::S_INS;
        end
      end
      sks_pkg::S_SHUP: begin
        if (flags.j_eq_p) begin
          state_nxt = sks_pkg::S_INS;
        end
      end
      sks_pkg::S_INS:  state_nxt = sks_pkg::S_IDLE;
      sks_pkg::S_RMRD: begin
        if (flags.idx_inc_lt_used) begin
          state_nxt = sks_pkg::S_SHDN;
        end else begin
          state_nxt = sks_pkg::S_IDLE;
        end
      end
      sks_pkg::S_SHDN: begin
        if (!flags.j_inc_lt_used) begin
          state_nxt = sks_pkg::S_IDLE;
        end
      end
      sks_pkg::S_RDRD: state_nxt = sks_pkg::S_IDLE;
      default:         state_nxt = sks_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      sks_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (sks_pkg::opcode_t'(in_opcode))
            sks_pkg::OP_FIND, sks_pkg::OP_INSERT: begin
              if (!flags.used_zero && flags.hint_lt_used) begin
                cmd.scan_hint = 1'b1;
              end else begin
                cmd.scan_zero = 1'b1;
              end
            end
            sks_pkg::OP_REMOVE, sks_pkg::OP_READ: begin
              if (flags.idx_in_ok) begin
                cmd.rd_idx = 1'b1;
              end else begin
                cmd.out_load = 1'b1;
                cmd.status   = sks_pkg::STAT_RANGE;
              end
            end
            sks_pkg::OP_CLEAR: begin
              cmd.commit_clr = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.status     = sks_pkg::STAT_OK;
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.status   = sks_pkg::STAT_RANGE;
            end
          endcase
        end
      end
      sks_pkg::S_HINT: begin
        if (flags.key_ge_rdata) begin
          cmd.scan_adv = 1'b1;
        end else begin
          cmd.scan_zero = 1'b1;
        end
      end
      sks_pkg::S_SCAN: begin
        if (flags.key_ge_rdata) begin
          cmd.scan_adv = 1'b1;
        end
      end
      sks_pkg::S_RESOLVE: begin
        if (flags.found) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = sks_pkg::OSEL_FOUND;
          cmd.status   = (flags.op == sks_pkg::OP_FIND) ? sks_pkg::STAT_OK
                                                         : sks_pkg::STAT_DUP;
        end else if (flags.op == sks_pkg::OP_FIND) begin
          cmd.out_load = 1'b1;
          cmd.status   = sks_pkg::STAT_MISS;
        end else if (flags.full) begin
          cmd.out_load = 1'b1;
          cmd.status   = sks_pkg::STAT_FULL;
        end else if (flags.used_gt_p) begin
          cmd.shup_begin = 1'b1;
        end
      end
      sks_pkg::S_SHUP: cmd.shup_step = 1'b1;
      sks_pkg::S_INS: begin
        cmd.ins_write  = 1'b1;
        cmd.commit_ins = 1'b1;
        cmd.out_load   = 1'b1;
        cmd.out_sel    = sks_pkg::OSEL_NEW;
        cmd.status     = sks_pkg::STAT_OK;
      end
      sks_pkg::S_RMRD: begin
        cmd.rm_capture = 1'b1;
        if (!flags.idx_inc_lt_used) begin
          cmd.commit_rm = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = sks_pkg::OSEL_RDATA_IDX;
          cmd.status    = sks_pkg::STAT_OK;
        end
      end
      sks_pkg::S_SHDN: begin
        cmd.shdn_step = 1'b1;
        if (!flags.j_inc_lt_used) begin
          cmd.commit_rm = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = sks_pkg::OSEL_HOLD_IDX;
          cmd.status    = sks_pkg::STAT_OK;
        end
      end
      sks_pkg::S_RDRD: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = sks_pkg::OSEL_RDATA_IDX;
        cmd.status   = sks_pkg::STAT_OK;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: sv/sks_dp.sv
// ----------------------------------------------------------------------------
// sks_dp : table datapath
// entry ram, scan and shift pointers, count and hint, result register
// ----------------------------------------------------------------------------
module sks_dp #(
  parameter int CAPACITY    = sks_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = sks_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = sks_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sks_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [sks_pkg::PORT_KEY_W-1:0]    in_search_key,
  input  logic [sks_pkg::PORT_VAL_W-1:0]    in_entry_value,
  input  logic [sks_pkg::INDEX_W-1:0]       in_entry_index,
  input  sks_pkg::dp_cmd_t                  cmd,
  output sks_pkg::dp_flags_t                flags,
  output logic                              out_valid,
  output logic [sks_pkg::STATUS_W-1:0]      out_status,
  output logic [sks_pkg::POS_W-1:0]         out_result_position,
  output logic [sks_pkg::PORT_KEY_W-1:0]    out_result_key,
  output logic [sks_pkg::PORT_VAL_W-1:0]    out_result_value,
  output logic [sks_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int EW   = KEY_WIDTH + VALUE_WIDTH;
  localparam int KIW  = (KEY_WIDTH < sks_pkg::PORT_KEY_W) ? KEY_WIDTH : sks_pkg::PORT_KEY_W;
  localparam int VIW  = (VALUE_WIDTH < sks_pkg::PORT_VAL_W) ? VALUE_WIDTH
                                                            : sks_pkg::PORT_VAL_W;
  localparam int CMPW = (CW > sks_pkg::INDEX_W) ? CW : sks_pkg::INDEX_W;

  // latched request
  sks_pkg::opcode_t       op_r,  op_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;

  // scan position, shift pointer, last entry passed
  logic [CW-1:0]          p_r,   p_nxt;
  logic [AW-1:0]          j_r,   j_nxt;
  logic [KEY_WIDTH-1:0]   hold_key_r, hold_key_nxt;
  logic [VALUE_WIDTH-1:0] hold_val_r, hold_val_nxt;
  logic                   hold_vld_r, hold_vld_nxt;

  // table state
  logic [CW-1:0]          used_r, used_nxt;
  logic [AW-1:0]          hint_r, hint_nxt;

  // result register
  logic                              out_valid_r,  out_valid_nxt;
  logic [sks_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [sks_pkg::POS_W-1:0]         out_pos_r,    out_pos_nxt;
  logic [sks_pkg::PORT_KEY_W-1:0]    out_key_r,    out_key_nxt;
  logic [sks_pkg::PORT_VAL_W-1:0]    out_val_r,    out_val_nxt;
  logic [sks_pkg::COUNT_W-1:0]       out_cnt_r,    out_cnt_nxt;

  // ram
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic [AW-1:0]          rd_addr;
  logic [EW-1:0]          rd_data;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  // derived values
  logic [CW-1:0]          p_inc;
  logic [CW-1:0]          used_dec;
  logic [CW-1:0]          j_wide_inc;
  logic [CW-1:0]          idx_wide_inc;

  sks_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key       = rd_data[EW-1:VALUE_WIDTH];
  assign rd_val       = rd_data[VALUE_WIDTH-1:0];
  assign p_inc        = p_r + CW'(1);
  assign used_dec     = used_r - CW'(1);
  assign j_wide_inc   = CW'(j_r) + CW'(1);
  assign idx_wide_inc = CW'(idx_r) + CW'(1);

  // status to the controller
  always_comb begin
    flags.op              = op_r;
    flags.used_zero       = (used_r == '0);
    flags.hint_lt_used    = (CW'(hint_r) < used_r);
    flags.key_ge_rdata    = (key_r >= rd_key);
    flags.p_inc_ge_used   = (p_inc >= used_r);
    flags.found           = hold_vld_r && (hold_key_r == key_r);
    flags.full            = (used_r >= CW'(CAPACITY));
    flags.used_gt_p       = (used_r > p_r);
    flags.j_eq_p          = (CW'(j_r) == p_r);
    flags.idx_in_ok       = (CMPW'(in_entry_index) < CMPW'(used_r));
    flags.idx_inc_lt_used = (idx_wide_inc < used_r);
    flags.j_inc_lt_used   = (j_wide_inc < used_r);
  end

  // ram addressing
  always_comb begin
    rd_addr = '0;
    if (cmd.scan_hint) begin
      rd_addr = hint_r;
    end else if (cmd.scan_adv) begin
      rd_addr = p_inc[AW-1:0];
    end else if (cmd.rd_idx) begin
      rd_addr = AW'(in_entry_index);
    end else if (cmd.rm_capture) begin
      rd_addr = idx_wide_inc[AW-1:0];
    end else if (cmd.shdn_step) begin
      rd_addr = j_wide_inc[AW-1:0];
    end else if (cmd.shup_begin) begin
      rd_addr = used_dec[AW-1:0];
    end else if (cmd.shup_step) begin
      rd_addr = j_r - AW'(1);
    end
  end

  always_comb begin
    wr_en   = cmd.shdn_step | cmd.shup_step | cmd.ins_write;
    wr_addr = p_r[AW-1:0];
    wr_data = rd_data;
    if (cmd.shdn_step) begin
      wr_addr = j_r - AW'(1);
    end else if (cmd.shup_step) begin
      wr_addr = j_wide_inc[AW-1:0];
    end else if (cmd.ins_write) begin
      wr_data = {key_r, val_r};
    end
  end

  // next values
  always_comb begin
    op_nxt       = op_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    p_nxt        = p_r;
    j_nxt        = j_r;
    hold_key_nxt = hold_key_r;
    hold_val_nxt = hold_val_r;
    hold_vld_nxt = hold_vld_r;
    used_nxt     = used_r;
    hint_nxt     = hint_r;

    if (cmd.load) begin
      op_nxt  = sks_pkg::opcode_t'(in_opcode);
      key_nxt = KEY_WIDTH'(in_search_key[KIW-1:0]);
      val_nxt = VALUE_WIDTH'(in_entry_value[VIW-1:0]);
      idx_nxt = AW'(in_entry_index);
    end

    if (cmd.scan_hint) begin
      p_nxt        = CW'(hint_r);
      hold_vld_nxt = 1'b0;
    end else if (cmd.scan_zero) begin
      p_nxt        = '0;
      hold_vld_nxt = 1'b0;
    end else if (cmd.scan_adv) begin
      p_nxt        = p_inc;
      hold_key_nxt = rd_key;
      hold_val_nxt = rd_val;
      hold_vld_nxt = 1'b1;
    end

    if (cmd.rm_capture) begin
      hold_key_nxt = rd_key;
      hold_val_nxt = rd_val;
      j_nxt        = idx_wide_inc[AW-1:0];
    end else if (cmd.shdn_step) begin
      j_nxt = j_wide_inc[AW-1:0];
    end else if (cmd.shup_begin) begin
      j_nxt = used_dec[AW-1:0];
    end else if (cmd.shup_step) begin
      j_nxt = j_r - AW'(1);
    end

    if (cmd.commit_ins) begin
      used_nxt = used_r + CW'(1);
      hint_nxt = p_r[AW-1:0];
    end else if (cmd.commit_rm) begin
      used_nxt = used_dec;
      if (used_dec == '0) begin
        hint_nxt = '0;
      end else if (CW'(hint_r) >= used_dec) begin
        hint_nxt = used_dec[AW-1:0] - AW'(1);
      end
    end else if (cmd.commit_clr) begin
      used_nxt = '0;
      hint_nxt = '0;
    end
  end

  // result
  always_comb begin
    out_valid_nxt  = cmd.out_load;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_key_nxt    = out_key_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    if (cmd.out_load) begin
      out_status_nxt = cmd.status;
      out_cnt_nxt    = sks_pkg::COUNT_W'(used_nxt);
      case (cmd.out_sel)
        sks_pkg::OSEL_FOUND: begin
          out_pos_nxt = sks_pkg::POS_W'(p_r - CW'(1));
          out_key_nxt = sks_pkg::PORT_KEY_W'(hold_key_r[KIW-1:0]);
          out_val_nxt = sks_pkg::PORT_VAL_W'(hold_val_r[VIW-1:0]);
        end
        sks_pkg::OSEL_NEW: begin
          out_pos_nxt = sks_pkg::POS_W'(p_r);
          out_key_nxt = sks_pkg::PORT_KEY_W'(key_r[KIW-1:0]);
          out_val_nxt = sks_pkg::PORT_VAL_W'(val_r[VIW-1:0]);
        end
        sks_pkg::OSEL_HOLD_IDX: begin
          out_pos_nxt = sks_pkg::POS_W'(idx_r);
          out_key_nxt = sks_pkg::PORT_KEY_W'(hold_key_r[KIW-1:0]);
          out_val_nxt = sks_pkg::PORT_VAL_W'(hold_val_r[VIW-1:0]);
        end
        sks_pkg::OSEL_RDATA_IDX: begin
          out_pos_nxt = sks_pkg::POS_W'(idx_r);
          out_key_nxt = sks_pkg::PORT_KEY_W'(rd_key[KIW-1:0]);
          out_val_nxt = sks_pkg::PORT_VAL_W'(rd_val[VIW-1:0]);
        end
        default: begin
          out_pos_nxt = '0;
          out_key_nxt = '0;
          out_val_nxt = '0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      hint_r      <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      hint_r      <= hint_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    p_r          <= p_nxt;
    j_r          <= j_nxt;
    hold_key_r   <= hold_key_nxt;
    hold_val_r   <= hold_val_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_key_r    <= out_key_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_position = out_pos_r;
  assign out_result_key      = out_key_r;
  assign out_result_value    = out_val_r;
  assign out_entry_count     = out_cnt_r;

endmodule

FILE: sv/sorted_key_set_engine.sv
// ----------------------------------------------------------------------------
// sorted_key_set_engine : sorted table of unique keys with value handles
// find, insert, remove by index, read by index and clear on a table kept in
// ascending key order in a single entry ram
// ----------------------------------------------------------------------------
//
//  channel   ports                                         transfer when
//  --------  --------------------------------------------  ------------------
//  request   in_opcode in_search_key in_entry_value         start && !busy
//            in_entry_index
//  result    out_status out_result_position out_result_key  out_valid (1 cycle)
//            out_result_value out_entry_count
//
//  timing: one ram read and one write a cycle; the walk over the table sets
//  the time from transfer to result: find scans, insert scans then shifts up,
//  remove shifts down, read needs no walk, clear and bad requests need no walk;
//  a new request may be taken while out_valid is shown
//  reset: synchronous, active low; table comes up empty, no clearing pass
//  the result side cannot stall: each result is shown for exactly one cycle
//
module sorted_key_set_engine #(
  parameter int CAPACITY    = sks_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = sks_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = sks_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [sks_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [sks_pkg::PORT_KEY_W-1:0]    in_search_key,
  input  logic [sks_pkg::PORT_VAL_W-1:0]    in_entry_value,
  input  logic [sks_pkg::INDEX_W-1:0]       in_entry_index,
  // result
  output logic                              out_valid,
  output logic [sks_pkg::STATUS_W-1:0]      out_status,
  output logic [sks_pkg::POS_W-1:0]         out_result_position,
  output logic [sks_pkg::PORT_KEY_W-1:0]    out_result_key,
  output logic [sks_pkg::PORT_VAL_W-1:0]    out_result_value,
  output logic [sks_pkg::COUNT_W-1:0]       out_entry_count
);

  // command and status bundles between sequencer and datapath
  sks_pkg::dp_cmd_t   cmd;
  sks_pkg::dp_flags_t flags;

  // sequencer: search from the last insert position when the key is not
  // below that entry, else from the start; then shift and write back
  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .flags     (flags),
    .cmd       (cmd),
    .busy      (busy)
  );

  // datapath: entry ram, pointers, entry count, hint and result register
  sks_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_opcode           (in_opcode),
    .in_search_key       (in_search_key),
    .in_entry_value      (in_entry_value),
    .in_entry_index      (in_entry_index),
    .cmd                 (cmd),
    .flags               (flags),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_result_position (out_result_position),
    .out_result_key      (out_result_key),
    .out_result_value    (out_result_value),
    .out_entry_count     (out_entry_count)
  );

endmodule

FILE: sv/sks_chk.sv
// ----------------------------------------------------------------------------
// sks_chk : port level checks of the sorted key set engine
// watches request acceptance, result strobes and result contents
// ----------------------------------------------------------------------------
module sks_chk #(
  parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [sks_pkg::STATUS_W-1:0]      out_status,
  input logic [sks_pkg::POS_W-1:0]         out_result_position,
  input logic [sks_pkg::PORT_KEY_W-1:0]    out_result_key,
  input logic [sks_pkg::PORT_VAL_W-1:0]    out_result_value,
  input logic [sks_pkg::COUNT_W-1:0]       out_entry_count
);

  // a transfer either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without request");

  // finishing work always shows a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("work ended without result");

  // failed lookups and range errors carry empty fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == sks_pkg::STAT_MISS ||
                   out_status == sks_pkg::STAT_FULL ||
                   out_status == sks_pkg::STAT_RANGE))
    |-> (out_result_position == '0 && out_result_key == '0 &&
         out_result_value == '0))
    else $error("failure result with non-zero fields");

  // entry count within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CAPACITY > 511) || (out_entry_count <= CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind sorted_key_set_engine sks_chk #(
  .CAPACITY (CAPACITY)
) u_sks_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_result_position (out_result_position),
  .out_result_key      (out_result_key),
  .out_result_value    (out_result_value),
  .out_entry_count     (out_entry_count)
);

FILE: verif/sorted_key_set_engine_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_set_engine_tb : self-checking bench for the sorted key set engine
// a table of directed requests, then random traffic over empty, small and full
// tables; every result is checked field by field against a behavioural copy
// of the table kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_set_engine_tb;

  localparam int OPCODE_W   = sks_pkg::OPCODE_W;
  localparam int PORT_KEY_W = sks_pkg::PORT_KEY_W;
  localparam int PORT_VAL_W = sks_pkg::PORT_VAL_W;
  localparam int INDEX_W    = sks_pkg::INDEX_W;
  localparam int STATUS_W   = sks_pkg::STATUS_W;
  localparam int POS_W      = sks_pkg::POS_W;
  localparam int COUNT_W    = sks_pkg::COUNT_W;

  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int TABLE_DEPTH  = sks_pkg::CAPACITY_DEF;
  // longest single request is an insert: scan plus shift up; the tail
  // below leaves a wide margin over it
  localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 8;
  localparam int DRAIN_LIMIT  = 4 * TABLE_DEPTH + 64;
  // timeout for the whole run, well above the slowest clean run
  localparam longint TIMEOUT_NS = 64'd20_000_000;
  localparam int MAX_REPORTED = 40;
  localparam int NUM_DIRECTED = 26;

  // opcodes the block does not decode
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI  = 3'd7;

  localparam logic [PORT_KEY_W-1:0] KEY_MAX = {PORT_KEY_W{1'b1}};
  localparam logic [PORT_VAL_W-1:0] VAL_MAX = {PORT_VAL_W{1'b1}};

  typedef struct packed {
    sks_pkg::status_t      status;
    logic [POS_W-1:0]      pos;
    logic [PORT_KEY_W-1:0] key;
    logic [PORT_VAL_W-1:0] value;
    logic [COUNT_W-1:0]    count;
  } table_result_t;

  // one row of the directed table; pinned rows carry a hand-written result
  typedef struct {
    logic [OPCODE_W-1:0]   op;
    logic [PORT_KEY_W-1:0] key;
    logic [PORT_VAL_W-1:0] value;
    logic [INDEX_W-1:0]    idx;
    bit                    pinned;
    table_result_t         res;
  } directed_row_t;

  localparam bit            PINNED   = 1'b1;
  localparam bit            PREDICT  = 1'b0;
  localparam table_result_t NO_RES   = '0;

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic [OPCODE_W-1:0]   in_opcode      = '0;
  logic [PORT_KEY_W-1:0] in_search_key  = '0;
  logic [PORT_VAL_W-1:0] in_entry_value = '0;
  logic [INDEX_W-1:0]    in_entry_index = '0;

  logic                  busy;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [POS_W-1:0]      out_result_position;
  logic [PORT_KEY_W-1:0] out_result_key;
  logic [PORT_VAL_W-1:0] out_result_value;
  logic [COUNT_W-1:0]    out_entry_count;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  sorted_key_set_engine DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_search_key       (in_search_key),
    .in_entry_value      (in_entry_value),
    .in_entry_index      (in_entry_index),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_result_position (out_result_position),
    .out_result_key      (out_result_key),
    .out_result_value    (out_result_value),
    .out_entry_count     (out_entry_count)
  );

  // --------------------------------------------------------------------------
  // behavioural copy of the table
  // --------------------------------------------------------------------------
  logic [PORT_KEY_W-1:0] tbl_keys   [TABLE_DEPTH];
  logic [PORT_VAL_W-1:0] tbl_values [TABLE_DEPTH];
  int                    tbl_used = 0;
  int                    tbl_hint = 0;

  table_result_t pending_results [$];
  directed_row_t directed_rows [NUM_DIRECTED];
  int            mismatch_count  = 0;
  int            results_checked = 0;

  // search from just past the last insert when the key is not below it,
  // otherwise from the bottom; either way the answer is the same
  function automatic bit locate_key(input logic [PORT_KEY_W-1:0] key, output int slot);
    int p;
    p = 0;
    if (tbl_used > 0) begin
      if (tbl_hint < tbl_used && key >= tbl_keys[tbl_hint]) p = tbl_hint + 1;
      while (p < tbl_used && !(key < tbl_keys[p])) p++;
    end
    if (p > 0 && tbl_keys[p-1] == key) begin
      slot = p - 1;
      return 1'b1;
    end
    slot = p;
    return 1'b0;
  endfunction

  // applies one request to the table copy and returns the result it gives
  function automatic table_result_t apply_table_op(input logic [OPCODE_W-1:0] op,
                                                   input logic [PORT_KEY_W-1:0] key,
                                                   input logic [PORT_VAL_W-1:0] value,
                                                   input logic [INDEX_W-1:0] idx);
    table_result_t r;
    int            slot;
    int            i;
    bit            hit;
    r = '0;
    r.status = sks_pkg::STAT_OK;
    case (op)
      sks_pkg::OP_FIND: begin
        hit = locate_key(key, slot);
        if (hit) begin
          r.pos   = slot[POS_W-1:0];
          r.key   = tbl_keys[slot];
          r.value = tbl_values[slot];
        end else begin
          r.status = sks_pkg::STAT_MISS;
        end
      end
      sks_pkg::OP_INSERT: begin
        hit = locate_key(key, slot);
        if (hit) begin
          r.status = sks_pkg::STAT_DUP;
          r.pos    = slot[POS_W-1:0];
          r.key    = tbl_keys[slot];
          r.value  = tbl_values[slot];
        end else if (tbl_used >= TABLE_DEPTH) begin
          r.status = sks_pkg::STAT_FULL;
        end else begin
          for (i = tbl_used; i > slot; i--) begin
            tbl_keys[i]   = tbl_keys[i-1];
            tbl_values[i] = tbl_values[i-1];
          end
          tbl_keys[slot]   = key;
          tbl_values[slot] = value;
          tbl_used++;
          tbl_hint = slot;
          r.pos   = slot[POS_W-1:0];
          r.key   = key;
          r.value = value;
        end
      end
      sks_pkg::OP_REMOVE: begin
        if (int'(idx) >= tbl_used) begin
          r.status = sks_pkg::STAT_RANGE;
        end else begin
          r.pos   = idx;
          r.key   = tbl_keys[idx];
          r.value = tbl_values[idx];
          tbl_used--;
          for (i = idx; i < tbl_used; i++) begin
            tbl_keys[i]   = tbl_keys[i+1];
            tbl_values[i] = tbl_values[i+1];
          end
          if (tbl_used == 0) tbl_hint = 0;
          else if (tbl_hint >= tbl_used) tbl_hint = tbl_used - 1;
        end
      end
      sks_pkg::OP_READ: begin
        if (int'(idx) >= tbl_used) begin
          r.status = sks_pkg::STAT_RANGE;
        end else begin
          r.pos   = idx;
          r.key   = tbl_keys[idx];
          r.value = tbl_values[idx];
        end
      end
      sks_pkg::OP_CLEAR: begin
        tbl_used = 0;
        tbl_hint = 0;
      end
      default: r.status = sks_pkg::STAT_RANGE;
    endcase
    r.count = tbl_used[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // result checker: the receiver cannot stall, so every strobe is a transfer
  // outputs are read at the edge, before the block's own updates land
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    table_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_checked));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_checked, out_status, want.status));
        if (out_result_position !== want.pos)
          report_mismatch($sformatf("result %0d position %0d, want %0d",
                                    results_checked, out_result_position, want.pos));
        if (out_result_key !== want.key)
          report_mismatch($sformatf("result %0d key %h, want %h",
                                    results_checked, out_result_key, want.key));
        if (out_result_value !== want.value)
          report_mismatch($sformatf("result %0d value %h, want %h",
                                    results_checked, out_result_value, want.value));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("result %0d count %0d, want %0d",
                                    results_checked, out_entry_count, want.count));
      end
      results_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // present one request and hold it until the block takes it; returns at the
  // transfer edge with start still high, so back-to-back requests need no dip
  task automatic send_op(input logic [OPCODE_W-1:0] op,
                         input logic [PORT_KEY_W-1:0] key,
                         input logic [PORT_VAL_W-1:0] value,
                         input logic [INDEX_W-1:0] idx,
                         input bit pinned,
                         input table_result_t pinned_res);
    table_result_t want;
    start          <= 1'b1;
    in_opcode      <= op;
    in_search_key  <= key;
    in_entry_value <= value;
    in_entry_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    // transfer has happened: the table copy moves on, pinned rows win
    want = apply_table_op(op, key, value, idx);
    pending_results.push_back(pinned ? pinned_res : want);
  endtask

  // random idle cycles with start low; the data lines carry junk meanwhile
  task automatic idle_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start          <= 1'b0;
      in_opcode      <= OPCODE_W'($urandom);
      in_search_key  <= $urandom;
      in_entry_value <= $urandom;
      in_entry_index <= INDEX_W'($urandom);
      @(posedge clk);
    end
  endtask

  // hold off until every outstanding result is back, with a cycle guard
  task automatic drain_results();
    int guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_results.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  // keys: often ones already stored (hits, duplicates), a small dense range
  // to collide, the two extremes, and full-width random for bit coverage
  function automatic logic [PORT_KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 && tbl_used > 0) return tbl_keys[$urandom_range(0, tbl_used - 1)];
    if (r < 52) return $urandom_range(0, 1) ? KEY_MAX : '0;
    if (r < 75) return $urandom_range(0, 63);
    return $urandom;
  endfunction

  // indexes: mostly in range, sometimes exactly the count, sometimes anything
  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70 && tbl_used > 0) return INDEX_W'($urandom_range(0, tbl_used - 1));
    if (r < 80) return INDEX_W'(tbl_used);
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  // one random request; without allow_clear no clear opcode is sent
  task automatic random_request(input bit allow_clear);
    logic [OPCODE_W-1:0] op;
    int unsigned         r;
    r = $urandom_range(0, 99);
    if (r < 32)      op = sks_pkg::OP_INSERT;
    else if (r < 56) op = sks_pkg::OP_FIND;
    else if (r < 70) op = sks_pkg::OP_READ;
    else if (r < 84) op = sks_pkg::OP_REMOVE;
    else if (r < 87) op = allow_clear ? sks_pkg::OP_CLEAR : sks_pkg::OP_FIND;
    else if (r < 91) op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else begin
      // noise: any opcode at all, clear only when allowed
      op = OPCODE_W'($urandom);
      if (!allow_clear && op == sks_pkg::OP_CLEAR) op = sks_pkg::OP_READ;
    end
    send_op(op, pick_key(), $urandom, pick_index(), PREDICT, NO_RES);
  endtask

  task automatic random_phase(input int count, input int pct, input bit allow_clear);
    repeat (count) begin
      random_request(allow_clear);
      idle_gap(pct);
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // directed table: empty table, extremes, duplicates, range errors,
    // undecoded opcodes, removal at both ends, clear
    directed_rows[0]  = '{sks_pkg::OP_FIND,   32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_MISS,  8'd0, 32'h0,   32'h0,   9'd0}};
    directed_rows[1]  = '{sks_pkg::OP_READ,   32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd0}};
    directed_rows[2]  = '{sks_pkg::OP_REMOVE, 32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd0}};
    directed_rows[3]  = '{sks_pkg::OP_INSERT, 32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_OK,    8'd0, 32'h0,   32'h0,   9'd1}};
    directed_rows[4]  = '{sks_pkg::OP_INSERT, KEY_MAX, VAL_MAX,       8'd255, PINNED,
                          '{sks_pkg::STAT_OK,    8'd1, KEY_MAX, VAL_MAX, 9'd2}};
    directed_rows[5]  = '{sks_pkg::OP_INSERT, 32'h0,   32'h1234_5678, 8'd0,   PINNED,
                          '{sks_pkg::STAT_DUP,   8'd0, 32'h0,   32'h0,   9'd2}};
    directed_rows[6]  = '{sks_pkg::OP_INSERT, KEY_MAX, 32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_DUP,   8'd1, KEY_MAX, VAL_MAX, 9'd2}};
    directed_rows[7]  = '{sks_pkg::OP_INSERT, 32'h8000_0000, 32'h5555_5555, 8'd0,
                          PREDICT, NO_RES};
    directed_rows[8]  = '{sks_pkg::OP_FIND,   32'h8000_0000, 32'h0,         8'd0,
                          PREDICT, NO_RES};
    // below the last insert: search has to start from the bottom
    directed_rows[9]  = '{sks_pkg::OP_FIND,   32'h7FFF_FFFF, 32'h0,   8'd0,   PINNED,
                          '{sks_pkg::STAT_MISS,  8'd0, 32'h0,   32'h0,   9'd3}};
    directed_rows[10] = '{sks_pkg::OP_FIND,   KEY_MAX, 32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_OK,    8'd2, KEY_MAX, VAL_MAX, 9'd3}};
    directed_rows[11] = '{sks_pkg::OP_READ,   32'h0,   32'h0,         8'd2,   PINNED,
                          '{sks_pkg::STAT_OK,    8'd2, KEY_MAX, VAL_MAX, 9'd3}};
    directed_rows[12] = '{sks_pkg::OP_READ,   32'h0,   32'h0,         8'd255, PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd3}};
    // index equal to the count is just out of range
    directed_rows[13] = '{sks_pkg::OP_READ,   32'h0,   32'h0,         8'd3,   PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd3}};
    directed_rows[14] = '{OP_UNUSED_LO,       KEY_MAX, VAL_MAX,       8'd255, PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd3}};
    directed_rows[15] = '{OP_UNUSED_MID,      32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd3}};
    directed_rows[16] = '{OP_UNUSED_HI,       KEY_MAX, 32'h0,         8'd1,   PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd3}};
    directed_rows[17] = '{sks_pkg::OP_INSERT, 32'h0000_0001, 32'hAAAA_AAAA, 8'd0,
                          PREDICT, NO_RES};
    // remove the first entry, then the last one
    directed_rows[18] = '{sks_pkg::OP_REMOVE, 32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_OK,    8'd0, 32'h0,   32'h0,   9'd3}};
    directed_rows[19] = '{sks_pkg::OP_REMOVE, 32'h0,   32'h0,         8'd2,   PINNED,
                          '{sks_pkg::STAT_OK,    8'd2, KEY_MAX, VAL_MAX, 9'd2}};
    directed_rows[20] = '{sks_pkg::OP_FIND,   32'h0000_0001, 32'h0,         8'd0,
                          PREDICT, NO_RES};
    directed_rows[21] = '{sks_pkg::OP_INSERT, 32'h4000_0000, 32'h0F0F_0F0F, 8'd0,
                          PREDICT, NO_RES};
    directed_rows[22] = '{sks_pkg::OP_READ,   32'h0,   32'h0,         8'd1,
                          PREDICT, NO_RES};
    directed_rows[23] = '{sks_pkg::OP_CLEAR,  KEY_MAX, VAL_MAX,       8'd255, PINNED,
                          '{sks_pkg::STAT_OK,    8'd0, 32'h0,   32'h0,   9'd0}};
    directed_rows[24] = '{sks_pkg::OP_REMOVE, 32'h0,   32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_RANGE, 8'd0, 32'h0,   32'h0,   9'd0}};
    directed_rows[25] = '{sks_pkg::OP_FIND,   KEY_MAX, 32'h0,         8'd0,   PINNED,
                          '{sks_pkg::STAT_MISS,  8'd0, 32'h0,   32'h0,   9'd0}};

    // single reset pulse at the start of the run
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
              directed_rows[i].idx, directed_rows[i].pinned, directed_rows[i].res);
      idle_gap(26);
    end

    // sender holds off until the block has answered everything
    drain_results();

    // small tables, back to back
    random_phase(100, 0, 1'b1);
    // small tables, sender mostly idle
    random_phase(80, 77, 1'b1);

    drain_results();

    // fill to capacity with wide random keys, then work a full table:
    // full and duplicate inserts, reads and removes up to the top index
    send_op(sks_pkg::OP_CLEAR, $urandom, $urandom, INDEX_W'($urandom), PREDICT, NO_RES);
    while (tbl_used < TABLE_DEPTH) begin
      send_op(sks_pkg::OP_INSERT, $urandom, $urandom, INDEX_W'($urandom), PREDICT, NO_RES);
      idle_gap(26);
    end
    send_op(sks_pkg::OP_READ, '0, '0, INDEX_W'(TABLE_DEPTH - 1), PREDICT, NO_RES);
    random_phase(30, 26, 1'b0);

    // the result side cannot stall, so its phase runs with a steady sender
    random_phase(50, 0, 1'b1);

    // wind down: everything back, then a quiet tail
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
